@@ rtl/rbdq_pkg.sv @@
// Shared types and constants for the transmit ring buffer with DMA bursts.
package rbdq_pkg;

    localparam int DEPTH  = 2048;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int BYTE_W = 8;

    localparam logic [ADDR_W-1:0] COUNT_MAX = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] USED_FULL = ADDR_W'(DEPTH - 1);
    localparam logic [LEN_W-1:0]  DEPTH_LEN = LEN_W'(DEPTH);

    // Widths of the packed stream payloads.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_READ     = 2'd2
    } req_type_t;

    // Access to the byte store from the control logic.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic              accepted;
        logic [ADDR_W-1:0] accepted_count;
        logic              burst_start;
        logic [ADDR_W-1:0] burst_index;
        logic [LEN_W-1:0]  burst_length;
        logic              is_read;
    } result_t;

endpackage

@@ rtl/ring_buffer_dma_burst_queue.sv @@
// Top level of the byte transmit ring buffer that issues contiguous DMA bursts.
//
//  Channel  Direction  tdata (low bit up)                          tuser     tlast
//  s_       in         byte_value[7:0] read_index[18:8]            req_type  last_byte
//  m_       out        accepted, accepted_count, burst_start,      -         -
//                      burst_index, burst_length, read_data
//
// Every transfer is handled in the cycle it is accepted and gives exactly one
// result, registered for the next cycle; one transfer per cycle is sustained
// while results are taken. The ring pointers and the byte store, with one write
// port and one registered read port, decide everything within that cycle.
// A synchronous active-low reset empties the ring and clears the burst state;
// the store contents are kept. A stalled result holds the input back only when
// the result register is full and not being taken.
module ring_buffer_dma_burst_queue
    import rbdq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // byte_value[7:0], read_index[18:8], zeros
    input  logic [S_TUSER_W-1:0] s_tuser,  // req_type[1:0]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // accepted[0], accepted_count[11:1],
                                           // burst_start[12], burst_index[23:13],
                                           // burst_length[35:24], read_data[43:36], zeros
);

    logic [ADDR_W-1:0] wr_ptr_reg,  wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg,  rd_ptr_next;
    logic              busy_reg,    busy_next;
    logic [LEN_W-1:0]  act_len_reg, act_len_next;
    logic [ADDR_W-1:0] call_cnt_reg, call_cnt_next;
    logic              m_valid_reg;
    result_t           res_reg, res_next;

    logic              s_fire;
    req_type_t         req;
    logic [BYTE_W-1:0] byte_value;
    logic [ADDR_W-1:0] read_index;
    logic [ADDR_W-1:0] used;
    logic              stored;
    logic [ADDR_W-1:0] cnt_inc;
    logic              try_start;
    logic              busy_eff;
    logic              can_start;
    logic [LEN_W-1:0]  start_len;
    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rd_data;

    assign s_tready   = !m_valid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign req        = req_type_t'(s_tuser);
    assign byte_value = s_tdata[BYTE_W-1:0];
    assign read_index = s_tdata[BYTE_W +: ADDR_W];

    // Pointer difference wraps naturally in the address width.
    assign used    = wr_ptr_reg - rd_ptr_reg;
    assign stored  = (used != USED_FULL);
    assign cnt_inc = (call_cnt_reg == COUNT_MAX) ? call_cnt_reg : call_cnt_reg + 1'b1;

    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        call_cnt_next = call_cnt_reg;
        busy_eff      = busy_reg;
        try_start     = 1'b0;
        res_next      = '0;

        unique case (req)
            REQ_WRITE: begin
                if (stored) begin
                    wr_ptr_next   = wr_ptr_reg + 1'b1;
                    call_cnt_next = cnt_inc;
                end
                res_next.accepted = stored;
                if (s_tlast) begin
                    res_next.accepted_count = call_cnt_next;
                    call_cnt_next           = '0;
                    try_start               = 1'b1;
                end
            end
            REQ_COMPLETE: begin
                if (busy_reg) begin
                    rd_ptr_next = rd_ptr_reg + act_len_reg[ADDR_W-1:0];
                    busy_eff    = 1'b0;
                    try_start   = 1'b1;
                end
            end
            REQ_READ: begin
                res_next.is_read = 1'b1;
            end
            default: begin
            end
        endcase

        // A burst stops at the write pointer or at the end of the buffer.
        can_start = try_start && !busy_eff && (wr_ptr_next != rd_ptr_next);
        if (wr_ptr_next > rd_ptr_next) begin
            start_len = LEN_W'(wr_ptr_next - rd_ptr_next);
        end else begin
            start_len = DEPTH_LEN - LEN_W'(rd_ptr_next);
        end

        busy_next    = busy_eff;
        act_len_next = act_len_reg;
        if (can_start) begin
            busy_next             = 1'b1;
            act_len_next          = start_len;
            res_next.burst_start  = 1'b1;
            res_next.burst_index  = rd_ptr_next;
            res_next.burst_length = start_len;
        end
    end

    always_comb begin
        ram_req.wr_en   = s_fire && (req == REQ_WRITE) && stored;
        ram_req.wr_addr = wr_ptr_reg;
        ram_req.wr_data = byte_value;
        ram_req.rd_en   = s_fire && (req == REQ_READ);
        ram_req.rd_addr = read_index;
    end

    rbdq_store u_store (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            busy_reg     <= 1'b0;
            act_len_reg  <= '0;
            call_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                wr_ptr_reg   <= wr_ptr_next;
                rd_ptr_reg   <= rd_ptr_next;
                busy_reg     <= busy_next;
                act_len_reg  <= act_len_next;
                call_cnt_reg <= call_cnt_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0,
                       res_reg.is_read ? ram_rd_data : {BYTE_W{1'b0}},
                       res_reg.burst_length,
                       res_reg.burst_index,
                       res_reg.burst_start,
                       res_reg.accepted_count,
                       res_reg.accepted};

`ifndef ASSERT_OFF
    // An active burst always covers at least one byte and never more than the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (act_len_reg != '0) && (act_len_reg <= DEPTH_LEN))
        else $error("active burst length out of range");

    // A result that announces a burst carries a non-empty burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.burst_start |-> (res_reg.burst_length != '0))
        else $error("burst started with zero length");

    // Retiring a burst leaves the block busy only if a new burst was reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (req == REQ_COMPLETE) && busy_reg |=> (busy_reg == res_reg.burst_start))
        else $error("busy flag disagrees with burst start after completion");
`endif

endmodule

@@ rtl/rbdq_store.sv @@
// Byte store of the ring: one write port and one registered read port.
module rbdq_store
    import rbdq_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          ram_req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
        if (ram_req.rd_en) begin
            rd_data_reg <= mem[ram_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the transmit ring buffer with contiguous DMA bursts.
`timescale 1ns / 100ps

module tb;
    import rbdq_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic              accepted;
        logic [ADDR_W-1:0] accepted_count;
        logic              burst_start;
        logic [ADDR_W-1:0] burst_index;
        logic [LEN_W-1:0]  burst_length;
        logic [BYTE_W-1:0] read_data;
    } ring_response_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // byte_value[7:0], read_index[18:8], zeros
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // req_type[1:0]
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // accepted[0], accepted_count[11:1], burst_start[12],
                                     // burst_index[23:13], burst_length[35:24],
                                     // read_data[43:36], zeros

    ring_buffer_dma_burst_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the ring and its burst bookkeeping.
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    bit                ring_written [DEPTH];
    logic [ADDR_W-1:0] wr_ptr   = '0;
    logic [ADDR_W-1:0] rd_ptr   = '0;
    logic              busy     = 1'b0;
    logic [LEN_W-1:0]  act_len  = '0;
    logic [ADDR_W-1:0] call_cnt = '0;

    ring_response_t responses_due [$];
    int  error_count  = 0;
    int  result_count = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    bit  no_idle      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_used();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_index();
        return ADDR_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Opens a burst from the read pointer when the engine is free and data waits.
    function automatic void open_burst(inout ring_response_t r);
        logic [LEN_W-1:0] len;
        if (busy || wr_ptr == rd_ptr) return;
        if (wr_ptr > rd_ptr) len = LEN_W'(wr_ptr - rd_ptr);
        else len = DEPTH_LEN - LEN_W'(rd_ptr);
        busy           = 1'b1;
        act_len        = len;
        r.burst_start  = 1'b1;
        r.burst_index  = rd_ptr;
        r.burst_length = len;
    endfunction

    function automatic ring_response_t predict_ring_step(input logic [1:0] req,
            input logic [BYTE_W-1:0] val, input logic last, input logic [ADDR_W-1:0] idx);
        ring_response_t r;
        r = '0;
        if (req == REQ_WRITE) begin
            if (ring_used() < USED_FULL) begin
                ring_mem[wr_ptr]     = val;
                ring_written[wr_ptr] = 1'b1;
                wr_ptr     = wr_ptr + 1'b1;
                r.accepted = 1'b1;
                if (call_cnt < COUNT_MAX) call_cnt = call_cnt + 1'b1;
            end
            if (last) begin
                r.accepted_count = call_cnt;
                call_cnt = '0;
                open_burst(r);
            end
        end else if (req == REQ_COMPLETE) begin
            if (busy) begin
                rd_ptr = rd_ptr + act_len[ADDR_W-1:0];
                busy   = 1'b0;
                open_burst(r);
            end
        end else if (req == REQ_READ) begin
            r.read_data = ring_mem[idx];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in result %0d: %s got %0d, expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Drives one request and waits for its transfer; tvalid stays high afterwards so
    // that back-to-back requests need no second assignment in the same step.
    task automatic send_req(input logic [1:0] req, input logic [BYTE_W-1:0] val,
                            input logic last, input logic [ADDR_W-1:0] idx);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= S_TDATA_W'({idx, val});
        do @(posedge aclk); while (!s_tready);
        responses_due.push_back(predict_ring_step(req, val, last, idx));
    endtask

    task automatic send_noise(input logic [1:0] req);
        send_req(req, rand_byte(), 1'($urandom_range(0, 1)), rand_index());
    endtask

    task automatic send_write(input logic [BYTE_W-1:0] val, input logic last);
        send_req(REQ_WRITE, val, last, rand_index());
    endtask

    task automatic send_read(input logic [ADDR_W-1:0] idx);
        send_req(REQ_READ, rand_byte(), 1'($urandom_range(0, 1)), idx);
    endtask

    task automatic test_short_calls();
        send_noise(REQ_COMPLETE);               // completion with no burst running
        send_noise(REQ_UNUSED);
        send_req(REQ_WRITE, 8'h00, 1'b0, 11'h7FF);
        send_req(REQ_WRITE, 8'hFF, 1'b1, 11'h000);
        send_write(8'h5A, 1'b1);                // call ends while a burst is busy
        send_noise(REQ_COMPLETE);
        send_req(REQ_READ, 8'hFF, 1'b1, 11'd0);
        send_req(REQ_READ, 8'h00, 1'b0, 11'd1);
        send_read(11'd2);
        send_noise(REQ_COMPLETE);
        send_noise(REQ_COMPLETE);
        send_write(8'h81, 1'b0);
        send_noise(REQ_COMPLETE);               // idle completion in the middle of a call
        send_write(8'h7E, 1'b1);
        send_req(REQ_UNUSED, 8'hFF, 1'b1, 11'h7FF);
        send_noise(REQ_COMPLETE);
    endtask

    // Fills the ring to the brim, drops bytes, and keeps one call going long enough
    // for its count to saturate while bursts retire underneath it. This also writes
    // every entry of the store, so any position may be read afterwards.
    task automatic test_ring_full();
        while (busy) send_noise(REQ_COMPLETE);
        send_write(rand_byte(), 1'b1);
        while (ring_used() < USED_FULL) send_write(rand_byte(), 1'b0);
        repeat (3) send_write(rand_byte(), 1'b0);
        send_noise(REQ_COMPLETE);
        send_write(rand_byte(), 1'b0);
        send_write(rand_byte(), 1'b0);
        send_noise(REQ_COMPLETE);
        repeat (10) send_write(rand_byte(), 1'b0);
        send_write(8'hC3, 1'b1);
        send_read(11'h7FF);
        send_read(11'h400);
        send_read(11'h555);
        send_read(11'h2AA);
        send_read(11'h000);
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int roll;
        logic [ADDR_W-1:0] idx;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_write(rand_byte(), k == len - 1);
                sent += len;
            end else if (roll < 72) begin
                send_noise(REQ_COMPLETE);
                if (busy || $urandom_range(0, 1)) sent++;
            end else if (roll < 95) begin
                do idx = rand_index(); while (!ring_written[idx]);
                send_read(idx);
                sent++;
            end else begin
                send_noise(REQ_UNUSED);
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= idle_len();
        end
    end

    always @(posedge aclk) begin : check_results
        ring_response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (responses_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", 1, 0);
            end else begin
                want = responses_due.pop_front();
                if (m_tdata[0] !== want.accepted)
                    report_mismatch("accepted", m_tdata[0], want.accepted);
                if (m_tdata[11:1] !== want.accepted_count)
                    report_mismatch("accepted_count", m_tdata[11:1], want.accepted_count);
                if (m_tdata[12] !== want.burst_start)
                    report_mismatch("burst_start", m_tdata[12], want.burst_start);
                if (m_tdata[23:13] !== want.burst_index)
                    report_mismatch("burst_index", m_tdata[23:13], want.burst_index);
                if (m_tdata[35:24] !== want.burst_length)
                    report_mismatch("burst_length", m_tdata[35:24], want.burst_length);
                if (m_tdata[43:36] !== want.read_data)
                    report_mismatch("read_data", m_tdata[43:36], want.read_data);
            end
            result_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_short_calls();
        test_ring_full();
        test_random_traffic();
        // The last request was taken at this edge, so tvalid must drop at once.
        s_tvalid <= 1'b0;
        while (responses_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
